// ===== rtl/bfnbc_pkg.sv =====
// Shared types, constants and state codes for the Bloom filter bit counter.
package bfnbc_pkg;

   localparam int unsigned MAX_CELLS_DEF  = 4096;
   localparam int unsigned MAX_HASHES_DEF = 8;
   localparam logic [31:0] SEED_BASE      = 32'd4224;

   localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MUR_C2 = 32'h1b873593;
   localparam logic [31:0] MUR_N1 = 32'he6546b64;
   localparam logic [31:0] MUR_F1 = 32'h85ebca6b;
   localparam logic [31:0] MUR_F2 = 32'hc2b2ae35;

   // Register byte addresses
   localparam logic [2:0] ADDR_CELLS  = 3'd0;
   localparam logic [2:0] ADDR_HASHES = 3'd4;

   // Transaction operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef struct packed {
      logic        op;
      logic [31:0] key;
   } req_type;

   typedef struct packed {
      logic [31:0] key_echo;
      logic [3:0]  new_bits;
      logic        seen_new;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_K1,
      ST_K2,
      ST_H1,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_F4,
      ST_MOD,
      ST_READ,
      ST_WAIT,
      ST_UPD,
      ST_OUT
   } state_type;

   // Request from the sequencer to the bit store
   typedef struct packed {
      logic        rd;
      logic        wr;
      logic        wdata;
      logic        clr;
   } mem_ctl_type;

endpackage

// ===== rtl/bfnbc_divider.sv =====
// Iterative restoring remainder unit: one quotient bit per cycle.
module bfnbc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [20:0] divisor,
   output logic        done,
   output logic [20:0] remainder
);
   import bfnbc_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [21:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [21:0] trial;

   // Shift in one dividend bit and subtract when it fits
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[20:0], quo_ff[31]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = busy_ff && (cnt_ff == 6'd1);
   assign remainder = rem_in[20:0];

`ifndef SYNTHESIS
   a_cnt_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != 6'd0)) else $error("divider busy with zero count");
   a_rem_small: assert property (@(posedge clock) disable iff (reset)
      $past(busy_ff) && !$past(start) |-> (rem_ff < {1'b0, divisor}))
      else $error("partial remainder not reduced");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
`endif
endmodule

// ===== rtl/bfnbc_store.sv =====
// Bit store: registered synchronous read, single write, sweeping clear.
module bfnbc_store #(
   parameter int unsigned MAX_CELLS = bfnbc_pkg::MAX_CELLS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bfnbc_pkg::mem_ctl_type       ctl,
   input  logic [((MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1)-1:0] addr,
   output logic                         rdata,
   output logic                         clr_busy
);
   import bfnbc_pkg::*;

   localparam int unsigned AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

   logic            mem [MAX_CELLS];
   logic [AW:0]     sweep_ff, sweep_in;
   logic            busy_ff, busy_in;
   logic            rdata_ff;

   // Sweep one entry per cycle after reset or a clear request
   always_comb begin
      sweep_in = sweep_ff;
      busy_in  = busy_ff;
      if (ctl.clr) begin
         sweep_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         sweep_in = sweep_ff + 1'b1;
         if (sweep_ff == (AW+1)'(MAX_CELLS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         busy_ff  <= 1'b1;
      end else begin
         sweep_ff <= sweep_in;
         busy_ff  <= busy_in;
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[sweep_ff[AW-1:0]] <= 1'b0;
      end else if (ctl.wr) begin
         mem[addr] <= ctl.wdata;
      end
      if (ctl.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata    = rdata_ff;
   assign clr_busy = busy_ff;

`ifndef SYNTHESIS
   a_no_wr_clr: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctl.wr && !ctl.rd) else $error("store access during clear");
   a_sweep_rng: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (sweep_ff < (AW+1)'(MAX_CELLS))) else $error("sweep out of range");
   a_clr_start: assert property (@(posedge clock) disable iff (reset)
      ctl.clr |=> busy_ff && (sweep_ff == '0)) else $error("clear did not start");
`endif
endmodule

// ===== rtl/bloom_filter_new_bit_counter_top.sv =====
// Insert: per hash, key and mix rounds, remainder, bit read-modify-write; then the
// result is registered. Clear: a clear request, then a sweep over all MAX_CELLS
// cells of the bit store. The 32-step remainder unit sets the hash loop pace. No
// new item is taken until the sequencer is idle, but one more is taken while the
// result register waits. Reset is synchronous; the store then sweeps all cells
// before an item is accepted; cells_ff resets to 4096, hashes_ff to 1.
module bloom_filter_new_bit_counter_top #(
   parameter int unsigned MAX_CELLS  = bfnbc_pkg::MAX_CELLS_DEF,
   parameter int unsigned MAX_HASHES = bfnbc_pkg::MAX_HASHES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bfnbc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bfnbc_pkg::rsp_type rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import bfnbc_pkg::*;

   localparam int unsigned AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int unsigned HW = $clog2(MAX_HASHES + 1);

   // Configuration registers
   logic [12:0] cells_ff;
   logic [3:0]  hashes_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff  <= 13'd4096;
         hashes_ff <= 4'd1;
      end else if (csr_wr) begin
         if (csr_paddr == ADDR_CELLS) begin
            cells_ff <= csr_pwdata[12:0];
         end else if (csr_paddr == ADDR_HASHES) begin
            hashes_ff <= csr_pwdata[3:0];
         end
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_CELLS:  csr_prdata = {19'd0, cells_ff};
         ADDR_HASHES: csr_prdata = {28'd0, hashes_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // Effective modulus and hash count, saturated; zero is taken as 1
   logic [20:0]   n_eff;
   logic [HW-1:0] hc_eff;
   always_comb begin
      if (cells_ff == 13'd0) begin
         n_eff = 21'd1;
      end else if (21'(cells_ff) > 21'(MAX_CELLS)) begin
         n_eff = 21'(MAX_CELLS);
      end else begin
         n_eff = 21'(cells_ff);
      end
      if (hashes_ff == 4'd0) begin
         hc_eff = HW'(1);
      end else if (32'(hashes_ff) > 32'(MAX_HASHES)) begin
         hc_eff = HW'(MAX_HASHES);
      end else begin
         hc_eff = HW'(hashes_ff);
      end
   end

   // Sequencer registers
   state_type     state_ff, state_in;
   logic [31:0]   key_ff, key_in;
   logic [31:0]   k_ff, k_in;
   logic [31:0]   h_ff, h_in;
   logic [HW-1:0] idx_ff, idx_in;
   logic [HW:0]   cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [AW-1:0] cell_ff, cell_in;
   logic          rv_ff, rv_in;
   rsp_type       rsp_ff, rsp_in;

   mem_ctl_type   mctl;
   logic          rdata, clr_busy;
   logic          div_start, div_done;
   logic [20:0]   div_rem;
   logic [31:0]   mag;
   logic [20:0]   cell_full;
   logic          accept;

   assign mag = neg_ff ? (32'd0 - h_ff) : h_ff;

   bfnbc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag),
      .divisor   (n_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   bfnbc_store #(.MAX_CELLS(MAX_CELLS)) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mctl),
      .addr     (cell_ff),
      .rdata    (rdata),
      .clr_busy (clr_busy)
   );

   assign req_stall = (state_ff != ST_IDLE) || clr_busy;
   assign accept    = req_valid && !req_stall;

   // Next state: clear request, hash rounds, remainder, bit read-modify-write, result
   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      k_in      = k_ff;
      h_in      = h_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      cell_in   = cell_ff;
      rv_in     = rv_ff && rsp_stall;
      rsp_in    = rsp_ff;
      mctl      = '0;
      div_start = 1'b0;
      cell_full = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_CLEAR) begin
                  state_in = ST_CLEAR;
               end else begin
                  key_in   = req_data.key;
                  idx_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_K1;
               end
            end
         end
         ST_CLEAR: begin
            mctl.clr = 1'b1;
            state_in = ST_IDLE;
         end
         ST_K1: begin
            k_in     = key_ff * MUR_C1;
            state_in = ST_K2;
         end
         ST_K2: begin
            k_in     = {k_ff[16:0], k_ff[31:17]} * MUR_C2;
            state_in = ST_H1;
         end
         ST_H1: begin
            h_in     = (SEED_BASE + 32'(idx_ff)) ^ k_ff;
            state_in = ST_F1;
         end
         ST_F1: begin
            h_in     = (({h_ff[18:0], h_ff[31:19]} * 32'd5) + MUR_N1) ^ 32'd4;
            state_in = ST_F2;
         end
         ST_F2: begin
            h_in     = (h_ff ^ (h_ff >> 16)) * MUR_F1;
            state_in = ST_F3;
         end
         ST_F3: begin
            h_in     = (h_ff ^ (h_ff >> 13)) * MUR_F2;
            state_in = ST_F4;
         end
         ST_F4: begin
            h_in     = h_ff ^ (h_ff >> 16);
            neg_in   = h_in[31];
            state_in = ST_MOD;
         end
         ST_MOD: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               if (neg_ff && (div_rem != 21'd0)) begin
                  cell_full = n_eff - div_rem;
               end else begin
                  cell_full = div_rem;
               end
               cell_in  = cell_full[AW-1:0];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mctl.rd  = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            mctl.wr    = 1'b1;
            mctl.wdata = 1'b1;
            if (!rdata) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (idx_ff == hc_eff - HW'(1)) begin
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + HW'(1);
               state_in = ST_K1;
            end
         end
         ST_OUT: begin
            if (!(rv_ff && rsp_stall)) begin
               rv_in           = 1'b1;
               rsp_in.key_echo = key_ff;
               rsp_in.new_bits = 4'(cnt_ff);
               rsp_in.seen_new = (cnt_ff != '0);
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      key_ff  <= key_in;
      k_ff    <= k_in;
      h_ff    <= h_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      cell_ff <= cell_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> (cnt_ff <= (HW+1)'(hc_eff)))
      else $error("new bit count exceeds hash count");
   a_seen: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> (rsp_ff.seen_new == (rsp_ff.new_bits != 4'd0)))
      else $error("seen flag disagrees with count");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == ST_IDLE && !clr_busy)
      else $error("transaction accepted while busy");
`endif
endmodule
